// ===== src/ell_pkg.sv =====
// shared types, token codes and character tables for the expression lexer
`timescale 1ns / 1ps
package ell_pkg;

  localparam int TOK_POS_W = 16;
  localparam int TOK_LEN_W = 16;
  localparam logic [TOK_LEN_W-1:0] LEN_MAX = '1;

  localparam int ITEM_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH = 2;

  // character classes
  localparam logic [2:0] CL_SINGLE = 3'd0;
  localparam logic [2:0] CL_PEND   = 3'd1;
  localparam logic [2:0] CL_QUOTE  = 3'd2;
  localparam logic [2:0] CL_DIGIT  = 3'd3;
  localparam logic [2:0] CL_ALPHA  = 3'd4;
  localparam logic [2:0] CL_SPACE  = 3'd5;
  localparam logic [2:0] CL_BAD    = 3'd6;
  localparam logic [2:0] CL_END    = 3'd7;

  // token kinds
  localparam logic [5:0] K_AND     = 6'd10;
  localparam logic [5:0] K_OR      = 6'd12;
  localparam logic [5:0] K_ASSIGN  = 6'd14;
  localparam logic [5:0] K_NOT     = 6'd16;
  localparam logic [5:0] K_LT      = 6'd18;
  localparam logic [5:0] K_GT      = 6'd20;
  localparam logic [5:0] K_STRING  = 6'd22;
  localparam logic [5:0] K_NUMBER  = 6'd23;
  localparam logic [5:0] K_IDENT   = 6'd24;
  localparam logic [5:0] K_KW0     = 6'd25;
  localparam logic [5:0] K_BAD     = 6'd34;
  localparam logic [5:0] K_END     = 6'd35;
  localparam logic [5:0] K_BADCHAR = 6'd36;

  // error codes
  localparam logic [1:0] E_NONE    = 2'd0;
  localparam logic [1:0] E_BADCHAR = 2'd1;
  localparam logic [1:0] E_BADNUM  = 2'd2;
  localparam logic [1:0] E_UNTERM  = 2'd3;

  // keywords
  localparam int NUM_KW = 9;
  localparam int KW_MAX_LEN = 5;
  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX_LEN] = '{
    '{"t", "r", "u", "e", 8'h00},
    '{"f", "a", "l", "s", "e"},
    '{"l", "e", "t", 8'h00, 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00},
    '{"w", "h", "i", "l", "e"},
    '{"f", "o", "r", 8'h00, 8'h00},
    '{"t", "o", 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4, 3'd5, 3'd3, 3'd2
  };

  typedef struct packed {
    logic [2:0] cls;
    logic [7:0] ch;
    logic [5:0] op_kind;
  } item_t;

  typedef struct packed {
    logic [5:0]           kind;
    logic [TOK_POS_W-1:0] start;
    logic [TOK_LEN_W-1:0] length;
    logic [1:0]           err;
    logic [7:0]           bad;
    logic                 last;
  } res_t;

  function automatic logic [5:0] pend_single(input logic [7:0] c);
    case (c)
      "&":     pend_single = K_AND;
      "|":     pend_single = K_OR;
      "=":     pend_single = K_ASSIGN;
      "!":     pend_single = K_NOT;
      "<":     pend_single = K_LT;
      default: pend_single = K_GT;
    endcase
  endfunction

  function automatic logic [7:0] pend_second(input logic [7:0] c);
    if (c == "&" || c == "|") begin
      pend_second = c;
    end else begin
      pend_second = "=";
    end
  endfunction

endpackage

// ===== src/ell_queue.sv =====
// small register queue between lexer stages
`timescale 1ns / 1ps
module ell_queue #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         full,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/ell_front.sv =====
// input side: accepts characters, classifies them and drops items after end
`timescale 1ns / 1ps
module ell_front
  import ell_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  input  logic       iq_full,
  output logic       iq_push,
  output item_t      iq_item
);

  logic finished_r, finished_nxt;
  logic accept;

  assign in_ready = finished_r || !iq_full;
  assign accept = in_valid && in_ready;
  assign iq_push = accept && !finished_r;

  always_comb begin
    iq_item.ch = in_char_code;
    iq_item.op_kind = '0;
    iq_item.cls = CL_BAD;
    if (in_kind || in_char_code == 8'h00) begin
      iq_item.cls = CL_END;
    end else begin
      case (in_char_code)
        "+": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd0; end
        "-": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd1; end
        "*": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd2; end
        "/": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd3; end
        "(": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd4; end
        ")": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd5; end
        "{": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd6; end
        "}": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd7; end
        "~": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd8; end
        "^": begin iq_item.cls = CL_SINGLE; iq_item.op_kind = 6'd9; end
        "&", "|", "=", "!", "<", ">": iq_item.cls = CL_PEND;
        "\"": iq_item.cls = CL_QUOTE;
        default: begin
          if (in_char_code inside {[8'h30:8'h39]}) begin
            iq_item.cls = CL_DIGIT;
          end else if (in_char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
            iq_item.cls = CL_ALPHA;
          end else if (in_char_code inside {8'h20, [8'h09:8'h0D]}) begin
            iq_item.cls = CL_SPACE;
          end else begin
            iq_item.cls = CL_BAD;
          end
        end
      endcase
    end
  end

  assign finished_nxt = finished_r || (iq_push && iq_item.cls == CL_END);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r <= 1'b0;
    end else begin
      finished_r <= finished_nxt;
    end
  end

endmodule

// ===== src/ell_back.sv =====
// scanner: tracks the open token; <=1 token per cycle if not stalled
`timescale 1ns / 1ps
module ell_back
  import ell_pkg::*;
#(
  parameter int POS_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  iq_empty,
  input  item_t iq_item,
  output logic  iq_pop,
  input  logic  oq_full,
  output logic  oq_push,
  output res_t  oq_res
);

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_PEND   = 3'd1;
  localparam logic [2:0] M_STRING = 3'd2;
  localparam logic [2:0] M_NUMBER = 3'd3;
  localparam logic [2:0] M_BADNUM = 3'd4;
  localparam logic [2:0] M_IDENT  = 3'd5;

  logic [2:0]           mode_r, mode_nxt;
  logic [7:0]           pend_r, pend_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;
  logic [TOK_LEN_W-1:0] run_r, run_nxt;
  logic [7:0]           prefix_r [KEYWORD_CHARS];
  logic [7:0]           prefix_nxt [KEYWORD_CHARS];

  logic                 fire;
  logic                 is_end, is_digit, is_alpha;
  logic                 close_last;
  logic [TOK_LEN_W-1:0] run_inc;
  logic [5:0]           word_kind;
  logic [POS_WIDTH-1:0] pos_inc;

  assign fire = !iq_empty && !oq_full;
  assign is_end = (iq_item.cls == CL_END);
  assign is_digit = (iq_item.cls == CL_DIGIT);
  assign is_alpha = (iq_item.cls == CL_ALPHA);
  assign close_last = !(iq_item.cls == CL_SINGLE || iq_item.cls == CL_BAD || is_end);
  assign run_inc = (run_r == LEN_MAX) ? run_r : run_r + 1'b1;
  assign pos_inc = pos_r + 1'b1;

  always_comb begin
    logic match;
    logic found;
    word_kind = K_IDENT;
    found = 1'b0;
    for (int i = 0; i < NUM_KW; i++) begin
      match = (run_r == TOK_LEN_W'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < int'(KW_LEN[i]) && prefix_r[j] != KW_TEXT[i][j]) begin
          match = 1'b0;
        end
      end
      if (match && !found) begin
        found = 1'b1;
        word_kind = K_KW0 + 6'(i);
      end
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    pos_nxt = pos_r;
    start_nxt = start_r;
    run_nxt = run_r;
    prefix_nxt = prefix_r;
    iq_pop = 1'b0;
    oq_push = 1'b0;
    oq_res.kind = K_END;
    oq_res.start = TOK_POS_W'(start_r);
    oq_res.length = run_r;
    oq_res.err = E_NONE;
    oq_res.bad = '0;
    oq_res.last = close_last;
    if (fire) begin
      case (mode_r)
        M_IDLE: begin
          iq_pop = 1'b1;
          oq_res.start = TOK_POS_W'(pos_r);
          oq_res.length = TOK_LEN_W'(1);
          oq_res.last = 1'b1;
          if (!is_end) begin
            pos_nxt = pos_inc;
          end
          case (iq_item.cls)
            CL_SINGLE: begin
              oq_push = 1'b1;
              oq_res.kind = iq_item.op_kind;
            end
            CL_PEND: begin
              mode_nxt = M_PEND;
              pend_nxt = iq_item.ch;
              start_nxt = pos_r;
            end
            CL_QUOTE: begin
              mode_nxt = M_STRING;
              start_nxt = pos_r;
              run_nxt = TOK_LEN_W'(1);
            end
            CL_DIGIT: begin
              mode_nxt = M_NUMBER;
              start_nxt = pos_r;
              run_nxt = TOK_LEN_W'(1);
            end
            CL_ALPHA: begin
              mode_nxt = M_IDENT;
              start_nxt = pos_r;
              run_nxt = TOK_LEN_W'(1);
              for (int j = 0; j < KEYWORD_CHARS; j++) begin
                prefix_nxt[j] = '0;
              end
              prefix_nxt[0] = iq_item.ch;
            end
            CL_BAD: begin
              oq_push = 1'b1;
              oq_res.kind = K_BADCHAR;
              oq_res.err = E_BADCHAR;
              oq_res.bad = iq_item.ch;
            end
            CL_END: begin
              oq_push = 1'b1;
              oq_res.kind = K_END;
              oq_res.length = '0;
            end
            default: begin
            end
          endcase
        end
        M_PEND: begin
          oq_push = 1'b1;
          mode_nxt = M_IDLE;
          if (!is_end && iq_item.ch == pend_second(pend_r)) begin
            iq_pop = 1'b1;
            pos_nxt = pos_inc;
            oq_res.kind = pend_single(pend_r) + 6'd1;
            oq_res.length = TOK_LEN_W'(2);
            oq_res.last = 1'b1;
          end else begin
            oq_res.kind = pend_single(pend_r);
            oq_res.length = TOK_LEN_W'(1);
          end
        end
        M_STRING: begin
          if (is_end) begin
            oq_push = 1'b1;
            mode_nxt = M_IDLE;
            oq_res.kind = K_BAD;
            oq_res.err = E_UNTERM;
          end else begin
            iq_pop = 1'b1;
            pos_nxt = pos_inc;
            run_nxt = run_inc;
            if (iq_item.ch == "\"") begin
              oq_push = 1'b1;
              mode_nxt = M_IDLE;
              oq_res.kind = K_STRING;
              oq_res.length = run_inc;
              oq_res.last = 1'b1;
            end
          end
        end
        M_NUMBER: begin
          if (is_digit || is_alpha) begin
            iq_pop = 1'b1;
            pos_nxt = pos_inc;
            run_nxt = run_inc;
            if (is_alpha) begin
              mode_nxt = M_BADNUM;
            end
          end else begin
            oq_push = 1'b1;
            mode_nxt = M_IDLE;
            oq_res.kind = K_NUMBER;
          end
        end
        M_BADNUM: begin
          if (is_digit || is_alpha) begin
            iq_pop = 1'b1;
            pos_nxt = pos_inc;
            run_nxt = run_inc;
          end else begin
            oq_push = 1'b1;
            mode_nxt = M_IDLE;
            oq_res.kind = K_BAD;
            oq_res.err = E_BADNUM;
          end
        end
        M_IDENT: begin
          if (is_digit || is_alpha) begin
            iq_pop = 1'b1;
            pos_nxt = pos_inc;
            run_nxt = run_inc;
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
              if (run_r == TOK_LEN_W'(j)) begin
                prefix_nxt[j] = iq_item.ch;
              end
            end
          end else begin
            oq_push = 1'b1;
            mode_nxt = M_IDLE;
            oq_res.kind = word_kind;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    start_r <= start_nxt;
    run_r <= run_nxt;
    prefix_r <= prefix_nxt;
  end

endmodule

// ===== src/expression_language_lexer.sv =====
// top level of the streaming expression lexer
`timescale 1ns / 1ps
// Streaming tokenizer: one character request per cycle goes in while the item
// queue has room, and tokens come out as soon as they close, each with kind,
// start position, saturating length, error code, offending byte and a
// last-of-run flag. A character that closes the token in progress without
// joining it (or the end item after an open token) stays in the item queue
// while the closed token is emitted and is then handled on its own; every
// other character is handled as it is taken. A two-entry queue on each side
// decouples input and output, so input keeps flowing while a result waits,
// until the item queue fills. Requests after the end item are accepted at one
// per cycle and discarded until reset.
module expression_language_lexer
  import ell_pkg::*;
#(
  parameter int POS_WIDTH = 16,
  parameter int KEYWORD_CHARS = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic [1:0]  out_error_code,
  output logic [7:0]  out_bad_char,
  output logic        out_last_of_run
);

  logic  iq_push, iq_pop, iq_full, iq_empty;
  item_t iq_in, iq_out;
  logic  oq_push, oq_full, oq_empty;
  res_t  oq_in, oq_out;

  ell_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .iq_full      (iq_full),
    .iq_push      (iq_push),
    .iq_item      (iq_in)
  );

  ell_queue #(
    .W     ($bits(item_t)),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (iq_push),
    .push_data (iq_in),
    .pop       (iq_pop),
    .pop_data  (iq_out),
    .full      (iq_full),
    .empty     (iq_empty)
  );

  ell_back #(
    .POS_WIDTH     (POS_WIDTH),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .iq_empty (iq_empty),
    .iq_item  (iq_out),
    .iq_pop   (iq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_res   (oq_in)
  );

  ell_queue #(
    .W     ($bits(res_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (oq_push),
    .push_data (oq_in),
    .pop       (out_valid && out_ready),
    .pop_data  (oq_out),
    .full      (oq_full),
    .empty     (oq_empty)
  );

  assign out_valid = !oq_empty;
  assign out_token_kind = oq_out.kind;
  assign out_token_start = oq_out.start;
  assign out_token_length = oq_out.length;
  assign out_error_code = oq_out.err;
  assign out_bad_char = oq_out.bad;
  assign out_last_of_run = oq_out.last;

endmodule

// ===== bench/tb_top.sv =====
// testbench for the expression lexer: scripted and random text checked against a token predictor
`timescale 1ns / 1ps
module tb_top
  import ell_pkg::*;
();

  localparam logic [5:0] K_PLUS   = 6'd0;
  localparam logic [5:0] K_MINUS  = 6'd1;
  localparam logic [5:0] K_STAR   = 6'd2;
  localparam logic [5:0] K_SLASH  = 6'd3;
  localparam logic [5:0] K_LPAREN = 6'd4;
  localparam logic [5:0] K_RPAREN = 6'd5;
  localparam logic [5:0] K_LBRACE = 6'd6;
  localparam logic [5:0] K_RBRACE = 6'd7;
  localparam logic [5:0] K_TILDE  = 6'd8;
  localparam logic [5:0] K_CARET  = 6'd9;
  localparam logic [5:0] K_TRUE   = K_KW0;
  localparam logic [5:0] K_FALSE  = K_KW0 + 6'd1;
  localparam logic [5:0] K_LET    = K_KW0 + 6'd2;
  localparam logic [5:0] K_VAR    = K_KW0 + 6'd3;
  localparam logic [5:0] K_IF     = K_KW0 + 6'd4;
  localparam logic [5:0] K_ELSE   = K_KW0 + 6'd5;
  localparam logic [5:0] K_WHILE  = K_KW0 + 6'd6;
  localparam logic [5:0] K_FOR    = K_KW0 + 6'd7;
  localparam logic [5:0] K_TO     = K_KW0 + 6'd8;

  localparam logic [15:0] RUN_TOP = 16'hFFFF;
  localparam int KW_CHARS = 5;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_TEXT = 40;
  localparam int PRINT_CAP = 40;

  typedef enum logic [2:0] {
    SC_IDLE, SC_PEND, SC_STRING, SC_NUMBER, SC_BADNUM, SC_IDENT
  } scan_t;

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic [1:0]  err;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_kind = 1'b0;
  logic [7:0]  in_char_code = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_token_kind;
  logic [15:0] out_token_start;
  logic [15:0] out_token_length;
  logic [1:0]  out_error_code;
  logic [7:0]  out_bad_char;
  logic        out_last_of_run;

  expression_language_lexer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_token_start  (out_token_start),
    .out_token_length (out_token_length),
    .out_error_code   (out_error_code),
    .out_bad_char     (out_bad_char),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  scan_t       sc_mode = SC_IDLE;
  logic [7:0]  sc_op = 8'h00;
  logic [15:0] sc_pos = 16'h0000;
  logic [15:0] sc_start = 16'h0000;
  logic [15:0] sc_len = 16'h0000;
  logic [39:0] sc_word = 40'h0;
  logic        sc_done = 1'b0;
  token_t      stage [2];
  int          stage_n = 0;
  token_t      tokens_due [$];

  int    in_idle_pct = 0;
  int    out_idle_pct = 0;
  int    items_sent = 0;
  int    mismatches = 0;
  int    hold_ticket = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  string op_chars = "+-*/(){}~^&|=!<>";
  string pair_chars = "&|=";
  token_t got;
  token_t want;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] c);
    case (c)
      "+":     op_kind = K_PLUS;
      "-":     op_kind = K_MINUS;
      "*":     op_kind = K_STAR;
      "/":     op_kind = K_SLASH;
      "(":     op_kind = K_LPAREN;
      ")":     op_kind = K_RPAREN;
      "{":     op_kind = K_LBRACE;
      "}":     op_kind = K_RBRACE;
      "~":     op_kind = K_TILDE;
      "^":     op_kind = K_CARET;
      "&":     op_kind = K_AND;
      "|":     op_kind = K_OR;
      "=":     op_kind = K_ASSIGN;
      "!":     op_kind = K_NOT;
      "<":     op_kind = K_LT;
      default: op_kind = K_GT;
    endcase
  endfunction

  // second character that turns a held operator into its two-character form
  function automatic logic [7:0] pair_char(input logic [7:0] c);
    if (c == "&" || c == "|") begin
      pair_char = c;
    end else begin
      pair_char = "=";
    end
  endfunction

  function automatic logic [5:0] word_kind();
    if (sc_len > KW_CHARS) return K_IDENT;
    case (sc_word)
      "true":  word_kind = K_TRUE;
      "false": word_kind = K_FALSE;
      "let":   word_kind = K_LET;
      "var":   word_kind = K_VAR;
      "if":    word_kind = K_IF;
      "else":  word_kind = K_ELSE;
      "while": word_kind = K_WHILE;
      "for":   word_kind = K_FOR;
      "to":    word_kind = K_TO;
      default: word_kind = K_IDENT;
    endcase
  endfunction

  function automatic void add_token(input logic [5:0] k, input logic [15:0] s,
                                    input logic [15:0] l, input logic [1:0] e,
                                    input logic [7:0] b);
    stage[stage_n] = {k, s, l, e, b, 1'b0};
    stage_n++;
  endfunction

  function automatic void grow_run();
    if (sc_len != RUN_TOP) sc_len = sc_len + 16'd1;
  endfunction

  function automatic void open_token(input logic [7:0] c);
    case (c)
      "+", "-", "*", "/", "(", ")", "{", "}", "~", "^": begin
        add_token(op_kind(c), sc_pos, 16'd1, E_NONE, 8'h00);
      end
      "&", "|", "=", "!", "<", ">": begin
        sc_mode = SC_PEND;
        sc_op = c;
        sc_start = sc_pos;
      end
      "\"": begin
        sc_mode = SC_STRING;
        sc_start = sc_pos;
        sc_len = 16'd1;
      end
      default: begin
        if (is_digit(c)) begin
          sc_mode = SC_NUMBER;
          sc_start = sc_pos;
          sc_len = 16'd1;
        end else if (is_alpha(c)) begin
          sc_mode = SC_IDENT;
          sc_start = sc_pos;
          sc_len = 16'd1;
          sc_word = {32'h0, c};
        end else if (!is_space(c)) begin
          add_token(K_BADCHAR, sc_pos, 16'd1, E_BADCHAR, c);
        end
      end
    endcase
  endfunction

  // advance the token predictor by one accepted request
  function automatic void scan_char(input logic end_flag, input logic [7:0] c);
    logic   at_end;
    logic   used;
    token_t t;
    at_end = end_flag || (c == 8'h00);
    used = 1'b0;
    stage_n = 0;
    if (sc_done) return;
    case (sc_mode)
      SC_PEND: begin
        if (!at_end && c == pair_char(sc_op)) begin
          add_token(op_kind(sc_op) + 6'd1, sc_start, 16'd2, E_NONE, 8'h00);
          sc_mode = SC_IDLE;
          used = 1'b1;
        end else begin
          add_token(op_kind(sc_op), sc_start, 16'd1, E_NONE, 8'h00);
        end
      end
      SC_STRING: begin
        if (at_end) begin
          add_token(K_BAD, sc_start, sc_len, E_UNTERM, 8'h00);
        end else begin
          grow_run();
          used = 1'b1;
          if (c == "\"") begin
            add_token(K_STRING, sc_start, sc_len, E_NONE, 8'h00);
            sc_mode = SC_IDLE;
          end
        end
      end
      SC_NUMBER: begin
        if (!at_end && is_digit(c)) begin
          grow_run();
          used = 1'b1;
        end else if (!at_end && is_alpha(c)) begin
          grow_run();
          sc_mode = SC_BADNUM;
          used = 1'b1;
        end else begin
          add_token(K_NUMBER, sc_start, sc_len, E_NONE, 8'h00);
        end
      end
      SC_BADNUM: begin
        if (!at_end && is_alnum(c)) begin
          grow_run();
          used = 1'b1;
        end else begin
          add_token(K_BAD, sc_start, sc_len, E_BADNUM, 8'h00);
        end
      end
      SC_IDENT: begin
        if (!at_end && is_alnum(c)) begin
          if (sc_len < KW_CHARS) sc_word = {sc_word[31:0], c};
          grow_run();
          used = 1'b1;
        end else begin
          add_token(word_kind(), sc_start, sc_len, E_NONE, 8'h00);
        end
      end
      default: ;
    endcase
    if (!used) sc_mode = SC_IDLE;
    if (at_end) begin
      add_token(K_END, sc_pos, 16'd0, E_NONE, 8'h00);
      sc_done = 1'b1;
    end else begin
      if (!used) open_token(c);
      sc_pos = sc_pos + 16'd1;
    end
    for (int i = 0; i < stage_n; i++) begin
      t = stage[i];
      t.last = (i == stage_n - 1);
      tokens_due.insert(tokens_due.size(), t);
    end
  endfunction

  // result side: random ready, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got.kind = out_token_kind;
      got.start = out_token_start;
      got.length = out_token_length;
      got.err = out_error_code;
      got.bad = out_bad_char;
      got.last = out_last_of_run;
      if (tokens_due.size() == 0) begin
        mismatches++;
        if (mismatches <= PRINT_CAP)
          $display("%0t: expected no token, got kind %0d start %0d len %0d", $time,
                   got.kind, got.start, got.length);
      end else begin
        want = tokens_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= PRINT_CAP)
            $display("%0t: expected kind %0d start %0d len %0d err %0d bad %0h last %0b,",
                     $time, want.kind, want.start, want.length, want.err, want.bad,
                     want.last, " got kind %0d start %0d len %0d err %0d bad %0h last %0b",
                     got.kind, got.start, got.length, got.err, got.bad, got.last);
        end
      end
    end
  end

  task automatic send_item(input logic k, input logic [7:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_char_code <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    scan_char(k, c);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  function automatic logic [7:0] rand_alpha();
    logic [7:0] c;
    c = 8'($urandom_range(25));
    return $urandom_range(1) ? "a" + c : "A" + c;
  endfunction

  function automatic logic [7:0] rand_alnum();
    logic [7:0] c;
    c = 8'($urandom_range(9));
    return ($urandom_range(2) == 0) ? "0" + c : rand_alpha();
  endfunction

  function automatic logic [7:0] rand_space();
    int r;
    r = $urandom_range(5);
    return (r == 0) ? " " : 8'(8 + r);
  endfunction

  function automatic string kw_text(input int i);
    case (i)
      0:       kw_text = "true";
      1:       kw_text = "false";
      2:       kw_text = "let";
      3:       kw_text = "var";
      4:       kw_text = "if";
      5:       kw_text = "else";
      6:       kw_text = "while";
      7:       kw_text = "for";
      default: kw_text = "to";
    endcase
  endfunction

  task automatic send_string_body(input int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(255, 1)); while (c == "\"");
      send_item(1'b0, c);
    end
  endtask

  // one random lexeme, mostly well formed, then maybe a separator
  task automatic send_random_piece();
    int r;
    r = $urandom_range(99);
    if (r < 22) begin
      send_item(1'b0, op_chars[$urandom_range(15)]);
      if ($urandom_range(9) < 4) send_item(1'b0, pair_chars[$urandom_range(2)]);
    end else if (r < 40) begin
      repeat ($urandom_range(4, 1)) send_item(1'b0, "0" + 8'($urandom_range(9)));
      if ($urandom_range(99) < 15) begin
        send_item(1'b0, rand_alpha());
        repeat ($urandom_range(2)) send_item(1'b0, rand_alnum());
      end
    end else if (r < 60) begin
      if ($urandom_range(9) < 4) begin
        send_text(kw_text($urandom_range(8)));
        if ($urandom_range(3) == 0) send_item(1'b0, rand_alnum());
      end else begin
        send_item(1'b0, rand_alpha());
        repeat ($urandom_range(7)) send_item(1'b0, rand_alnum());
      end
    end else if (r < 72) begin
      send_item(1'b0, "\"");
      send_string_body($urandom_range(6));
      send_item(1'b0, "\"");
    end else if (r < 85) begin
      send_item(1'b0, rand_space());
    end else begin
      send_item(1'b0, 8'($urandom_range(255, 1)));
    end
    if ($urandom_range(1)) send_item(1'b0, rand_space());
  endtask

  task automatic test_operators();
    send_text("+-*/(){}~^&&|=!<=>||==!=>=");
  endtask

  task automatic test_words();
    send_text("if false 9a \"\"");
    send_item(1'b0, 8'hFF);
  endtask

  task automatic test_random(input int n);
    int goal;
    goal = items_sent + n;
    while (items_sent < goal) send_random_piece();
  endtask

  // receiver stalls while the sender keeps offering operator requests
  task automatic test_backpressure();
    hold_ticket <= hold_ticket + 1;
    repeat (40) send_item(1'b0, op_chars[$urandom_range(9)]);
  endtask

  // one long string followed by a short mix of tokens
  task automatic test_long_run();
    send_item(1'b0, "\"");
    send_string_body(LONG_TEXT);
    send_item(1'b0, "\"");
    send_text(" x1 7 ");
  endtask

  task automatic test_end_of_input();
    logic       k;
    logic [7:0] c;
    case ($urandom_range(6))
      0:       send_text("a<");
      1:       send_text("\"ab");
      2:       send_text("42");
      3:       send_text("4x");
      4:       send_text("whil");
      5:       send_text("else");
      default: send_text(" ");
    endcase
    if ($urandom_range(1)) begin
      c = 8'($urandom_range(255));
      send_item(1'b1, c);
    end else begin
      send_item(1'b0, 8'h00);
    end
    // requests after the end are dropped
    repeat (8) begin
      k = 1'($urandom_range(1));
      c = 8'($urandom_range(255));
      send_item(k, c);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    in_idle_pct = 6;
    out_idle_pct = 61;
    test_operators();
    test_words();
    test_random(160);
    in_idle_pct = 61;
    out_idle_pct = 6;
    test_random(160);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_backpressure();
    test_random(160);
    test_long_run();
    test_end_of_input();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
